// ===== src/stepper_accel_ramp_generator_defines.svh =====
// Assertion macros for the stepper ramp generator
`ifndef STEPPER_ACCEL_RAMP_GENERATOR_DEFINES_SVH
`define STEPPER_ACCEL_RAMP_GENERATOR_DEFINES_SVH
`ifndef SYNTH
`define SARG_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define SARG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SARG_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define SARG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== src/sarg_pkg.sv =====
`default_nettype none
package sarg_pkg;
    localparam int FRAC_BITS_DEF = 12;
    localparam logic [31:0] START_INTERVAL_RST = 32'd43780096;
    localparam logic [19:0] ACCEL_RST = 20'd8000;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_MOVE  = 2'd1,
        OP_STOP  = 2'd2,
        OP_PAUSE = 2'd3
    } op_t;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_ACCEL = 1'b1;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG  = 2'd2;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_PAUSED = 2'd2;

    // queued item between front and back
    typedef struct packed {
        op_t         op;
        logic [31:0] target;
        logic [31:0] min_iv;
    } cmd_t;

    // result item
    typedef struct packed {
        logic        step_pulse;
        logic        direction;
        logic [31:0] position;
        logic [1:0]  status;
        logic [19:0] step_interval;
        logic        finished;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_STS_MUL0,
        S_STS_MUL1,
        S_STS_DIV,
        S_STS_DONE,
        S_PLAN,
        S_EQ_DIV,
        S_EQ_DONE,
        S_OUT
    } exec_state_t;
endpackage
`default_nettype wire

// ===== src/sarg_front.sv =====
`default_nettype none
// Input side: takes items into a two-entry queue
module sarg_front
    import sarg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire cmd_t        in_cmd,
    output logic             q_valid,
    input  wire logic        q_ready,
    output cmd_t             q_cmd
);
    cmd_t       mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_cmd;
    end
endmodule
`default_nettype wire

// ===== src/sarg_divider.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle
module sarg_divider #(
    parameter int NW = 64,
    parameter int DW = 64
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quot
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] n_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] c_reg;
    logic          busy_reg;
    logic [DW:0]   sh;
    logic          ge;

    assign sh   = {r_reg[DW-1:0], n_reg[NW-1]};
    assign ge   = sh >= {1'b0, d_reg};
    assign quot = n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && c_reg == CW'(NW - 1)) begin
                busy_reg <= 1'b0;
                done     <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg <= num;
            d_reg <= den;
            r_reg <= '0;
            c_reg <= '0;
        end else if (busy_reg) begin
            r_reg <= ge ? sh - {1'b0, d_reg} : sh;
            n_reg <= {n_reg[NW-2:0], ge};
            c_reg <= c_reg + 1'b1;
        end
    end
endmodule
`default_nettype wire

// ===== src/sarg_back.sv =====
`default_nettype none
`include "stepper_accel_ramp_generator_defines.svh"
// Execution side: ramp state, steps-to-stop and equation 13 sequencer
module sarg_back
    import sarg_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [31:0] start_interval,
    input  wire logic [19:0] acceleration,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  wire cmd_t        q_cmd,
    output logic             res_valid,
    input  wire logic        res_ready,
    output res_t             res
);
    // numerator 1e12 << 2F, 40 + 2F bits; wider quotient bits fold into saturation
    localparam int NW = 40 + 2 * FRAC_BITS;
    localparam logic [NW-1:0] NUM = NW'(64'd1000000000000) << (2 * FRAC_BITS);

    exec_state_t st_reg, st_next;
    cmd_t        cmd_reg;

    logic [31:0] pos_reg, tgt_reg, saved_reg, n_reg, iv_reg, floor_reg, since_reg;
    logic [19:0] rnd_reg;
    logic [1:0]  dir_reg;
    logic        moving_reg, paused_reg, idle_reg;
    logic [31:0] sts_reg;
    logic        pulse_reg, is_move_reg;
    logic [63:0] sq_reg;

    // shared divider
    logic          dv_start;
    logic [NW-1:0] dv_num;
    logic [84:0]   dv_den;
    logic          dv_done;
    logic [NW-1:0] dv_q;

    sarg_divider #(.NW(NW), .DW(85)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start), .num(dv_num),
        .den(dv_den), .done(dv_done), .quot(dv_q)
    );

    logic eq_phase;
    assign eq_phase = (st_reg == S_PLAN);

    // planning step
    logic signed [32:0] gap;
    logic [32:0]        adist;
    logic signed [31:0] ns;
    logic [31:0]        n_plan;
    logic [1:0]         dir_plan;
    logic               arrive;
    logic signed [33:0] d4;
    logic [33:0]        d4_mag;
    always_comb begin
        gap    = $signed({tgt_reg[31], tgt_reg}) - $signed({pos_reg[31], pos_reg});
        adist  = gap[32] ? 33'(-gap) : 33'(gap);
        ns     = $signed(n_reg);
        n_plan = n_reg;
        arrive = (gap == 0) && (sts_reg <= 32'd1);
        if (gap != 0) begin
            if (ns > 0) begin
                if ({1'b0, sts_reg} >= adist ||
                    dir_reg == (gap[32] ? DIR_POS : DIR_NEG))
                    n_plan = 32'd0 - sts_reg;
            end else if (ns < 0) begin
                if ({1'b0, sts_reg} < adist &&
                    dir_reg == (gap[32] ? DIR_NEG : DIR_POS))
                    n_plan = 32'd0 - n_reg;
            end
        end
        // zero distance restarts toward negative
        dir_plan = (!gap[32] && gap != 0) ? DIR_POS : DIR_NEG;
        d4     = ($signed({{2{n_plan[31]}}, n_plan}) <<< 2) + 34'sd1;
        d4_mag = d4[33] ? 34'(-d4) : 34'(d4);
    end

    // equation 13 finish
    logic [32:0] delta;
    logic [33:0] cn;
    logic [31:0] cn_sat, cn_fin;
    logic [36:0] rsum;
    always_comb begin
        delta = dv_q[32:0];
        if ($signed(n_reg) > 0)
            cn = (delta > {1'b0, iv_reg}) ? 34'd0 : {1'b0, {1'b0, iv_reg} - delta};
        else
            cn = {2'b0, iv_reg} + {1'b0, delta};
        cn_sat = (cn > 34'hFFFFFFFF) ? 32'hFFFFFFFF : cn[31:0];
        cn_fin = (cn_sat < floor_reg) ? floor_reg : cn_sat;
        if (cn_fin == 32'd0) cn_fin = 32'd1;
    end

    logic [31:0] cn_new;
    always_comb begin
        rsum = {5'b0, cn_new} + (37'd1 << (FRAC_BITS - 1));
    end

    logic [19:0] acc1;
    assign acc1 = (acceleration == 0) ? 20'd1 : acceleration;

    // next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE:     if (q_valid) st_next = S_DECODE;
            S_DECODE: begin
                priority if (cmd_reg.op == OP_MOVE)
                    st_next = S_STS_MUL0;
                else if (cmd_reg.op == OP_TICK && moving_reg &&
                         since_reg + {31'd0, since_reg != 32'hFFFFFFFF}
                            >= {12'd0, rnd_reg})
                    st_next = S_STS_MUL0;
                else
                    st_next = S_OUT;
            end
            S_STS_MUL0: st_next = (iv_reg == 0) ? S_STS_DONE : S_STS_MUL1;
            S_STS_MUL1: st_next = S_STS_DIV;
            S_STS_DIV:  if (dv_done) st_next = S_STS_DONE;
            S_STS_DONE: st_next = S_PLAN;
            S_PLAN: begin
                priority if (arrive) st_next = S_OUT;
                else if (n_plan == 0) st_next = S_OUT;
                else st_next = S_EQ_DIV;
            end
            S_EQ_DIV:   if (dv_done) st_next = S_EQ_DONE;
            S_EQ_DONE:  st_next = S_OUT;
            S_OUT:      if (!res_valid || res_ready) st_next = S_IDLE;
            default:    st_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        q_ready  = (st_reg == S_IDLE);
        dv_start = (st_reg == S_STS_MUL1) ||
                   (st_reg == S_PLAN && !arrive && n_plan != 0);
        cn_new   = (st_reg == S_EQ_DONE) ? cn_fin :
                   (start_interval == 0 ? 32'd1 : start_interval);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= S_IDLE;
            pos_reg    <= '0;
            tgt_reg    <= '0;
            saved_reg  <= '0;
            n_reg      <= '0;
            iv_reg     <= '0;
            floor_reg  <= 32'd1;
            rnd_reg    <= '0;
            since_reg  <= '0;
            dir_reg    <= DIR_NONE;
            moving_reg <= 1'b0;
            paused_reg <= 1'b0;
            idle_reg   <= 1'b0;
            res_valid  <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (res_valid && res_ready) res_valid <= 1'b0;
            unique case (st_reg)
                S_IDLE: if (q_valid) cmd_reg <= q_cmd;
                S_DECODE: begin
                    pulse_reg   <= 1'b0;
                    is_move_reg <= (cmd_reg.op == OP_MOVE);
                    unique case (cmd_reg.op)
                        OP_TICK: begin
                            if (moving_reg && since_reg + {31'd0,
                                since_reg != 32'hFFFFFFFF} >= {12'd0, rnd_reg}) begin
                                since_reg <= '0;
                                if (dir_reg == DIR_POS) pos_reg <= pos_reg + 32'd1;
                                else if (dir_reg == DIR_NEG) pos_reg <= pos_reg - 32'd1;
                                pulse_reg <= (dir_reg == DIR_POS || dir_reg == DIR_NEG);
                            end else if (since_reg != 32'hFFFFFFFF) begin
                                since_reg <= since_reg + 32'd1;
                            end
                        end
                        OP_MOVE: begin
                            tgt_reg   <= cmd_reg.target;
                            floor_reg <= (cmd_reg.min_iv == 0) ? 32'd1 : cmd_reg.min_iv;
                        end
                        OP_STOP: tgt_reg <= pos_reg;
                        OP_PAUSE: begin
                            paused_reg <= ~paused_reg;
                            if (!paused_reg) begin
                                saved_reg <= tgt_reg;
                                tgt_reg   <= pos_reg;
                            end else begin
                                tgt_reg <= saved_reg;
                            end
                        end
                        default: ;
                    endcase
                end
                S_STS_MUL0: begin
                    sq_reg  <= iv_reg * iv_reg;
                    sts_reg <= '0;
                end
                S_STS_MUL1: ;
                S_STS_DIV: ;
                S_STS_DONE: begin
                    if (iv_reg != 0)
                        sts_reg <= (|dv_q[NW-1:31]) ? 32'h7FFFFFFF : {1'b0, dv_q[30:0]};
                    if (is_move_reg && $signed(n_reg) > 0)
                        n_reg <= (iv_reg == 0) ? 32'd0 :
                                 ((|dv_q[NW-1:31]) ? 32'h7FFFFFFF : {1'b0, dv_q[30:0]});
                end
                S_PLAN: begin
                    if (arrive) begin
                        moving_reg <= 1'b0;
                        iv_reg     <= '0;
                        rnd_reg    <= '0;
                        n_reg      <= '0;
                    end else if (n_plan == 0) begin
                        dir_reg    <= dir_plan;
                        n_reg      <= 32'd1;
                        iv_reg     <= cn_new;
                        rnd_reg    <= (|rsum[36:FRAC_BITS+20]) ? 20'hFFFFF
                                      : rsum[FRAC_BITS+19:FRAC_BITS];
                        moving_reg <= 1'b1;
                    end else begin
                        n_reg <= n_plan;
                    end
                end
                S_EQ_DIV: ;
                S_EQ_DONE: begin
                    n_reg      <= n_reg + 32'd1;
                    iv_reg     <= cn_new;
                    rnd_reg    <= (|rsum[36:FRAC_BITS+20]) ? 20'hFFFFF
                                  : rsum[FRAC_BITS+19:FRAC_BITS];
                    moving_reg <= 1'b1;
                end
                S_OUT: begin
                    if (!res_valid || res_ready) begin
                        res_valid         <= 1'b1;
                        res.step_pulse    <= pulse_reg;
                        res.direction     <= (dir_reg == DIR_POS);
                        res.position      <= pos_reg;
                        res.status        <= moving_reg ? (paused_reg ? ST_PAUSED : ST_RUN)
                                                        : ST_IDLE;
                        res.step_interval <= moving_reg ? rnd_reg : 20'd0;
                        res.finished      <= 1'b0;
                        if (is_move_reg) idle_reg <= 1'b0;
                        else if (cmd_reg.op == OP_TICK) begin
                            if (!idle_reg && !moving_reg) begin
                                res.finished <= 1'b1;
                                idle_reg     <= 1'b1;
                            end else if (moving_reg) begin
                                idle_reg <= 1'b0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // denominator 2*a*I^2 from low and high 32-bit halves of sq times 21-bit 2a
    logic [52:0] p_lo;
    logic [52:0] p_hi;
    assign p_lo = {32'd0, acc1, 1'b0} * {21'd0, sq_reg[31:0]};
    assign p_hi = {32'd0, acc1, 1'b0} * {21'd0, sq_reg[63:32]};

    // divider operands: steps-to-stop, or equation 13 term while planning
    always_comb begin
        dv_num = eq_phase ? NW'({iv_reg, 1'b0}) : NUM;
        dv_den = eq_phase ? 85'(d4_mag) : ({32'd0, p_lo} + ({32'd0, p_hi} << 32));
    end

    `SARG_ASSERT_IMPL(a_no_take_busy, aclk, aresetn, q_ready, st_reg == S_IDLE,
        "queue popped while busy")
    `SARG_ASSERT_NEXT(a_pulse_moves, aclk, aresetn,
        st_reg == S_DECODE && cmd_reg.op != OP_TICK, pulse_reg == 1'b0,
        "pulse on non-tick item")
    `SARG_ASSERT_IMPL(a_floor_nz, aclk, aresetn, 1'b1, floor_reg != 32'd0,
        "interval floor zero")
endmodule
`default_nettype wire

// ===== src/stepper_accel_ramp_generator.sv =====
// Stop, pause and non-stepping ticks pass S_DECODE and S_OUT before m_tvalid; moves and
// stepping ticks also pass steps-to-stop, planning and any equation 13 division.
// The sequencer takes one item at a time, from S_IDLE; the shared serial divider (one bit
// per cycle, up to two divisions per long item) serves steps-to-stop and equation 13.
// A two-entry queue takes items while the sequencer works.
// Reset: synchronous active-low aresetn clears all ramp state and loads register defaults.
`default_nettype none
module stepper_accel_ramp_generator
    import sarg_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // opcode[1:0], target_position[33:2], min_interval[65:34], zero fill to 72
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // step_pulse[0], direction[1], position[33:2], status[35:34],
    // step_interval[55:36], finished[56], zero fill to 64
    output logic [63:0]      m_tdata
);
    logic [31:0] start_reg;
    logic [19:0] accel_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= START_INTERVAL_RST;
            accel_reg <= ACCEL_RST;
        end else if (cfg_we) begin
            if (cfg_index == CFG_START) start_reg <= cfg_data;
            else accel_reg <= cfg_data[19:0];
        end
    end

    cmd_t in_cmd, q_cmd;
    logic q_valid, q_ready;
    res_t res;
    always_comb begin
        in_cmd.op     = op_t'(s_tdata[1:0]);
        in_cmd.target = s_tdata[33:2];
        in_cmd.min_iv = s_tdata[65:34];
    end

    sarg_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    sarg_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .start_interval(start_reg),
        .acceleration(accel_reg), .q_valid(q_valid), .q_ready(q_ready),
        .q_cmd(q_cmd), .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
    );

    assign m_tdata = {7'd0, res.finished, res.step_interval, res.status,
                      res.position, res.direction, res.step_pulse};
endmodule
`default_nettype wire
